[src/mbi_pkg.sv]
// Shared types and constants for the motion burst integrator.
// No dependencies; used by motion_burst_integrator.
package mbi_pkg;

    // Field widths.
    localparam int unsigned ACCEL_W = 12;
    localparam int unsigned DEV_W   = ACCEL_W + 1;   // deviation after offset removal
    localparam int unsigned DSQ_W   = 2 * DEV_W;     // sum of two squared deviations
    localparam int unsigned VEL_W   = 22;
    localparam int unsigned VSQ_W   = 2 * VEL_W;
    localparam int unsigned TRV_W   = 32;
    localparam int unsigned FC_W    = 9;
    localparam int unsigned CFG_W   = 25;
    localparam int unsigned IDX_W   = 3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_REST_OFFSET_X     = 3'd0;
    localparam logic [IDX_W-1:0] REG_REST_OFFSET_Y     = 3'd1;
    localparam logic [IDX_W-1:0] REG_START_THRESHOLD   = 3'd2;
    localparam logic [IDX_W-1:0] REG_STOP_ACCEL_SQ     = 3'd3;
    localparam logic [IDX_W-1:0] REG_STOP_VEL_THRESH   = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_FRAMES        = 3'd5;

    // Configuration reset values.
    localparam logic signed [11:0] REST_OFFSET_X_RST = 12'sd0;
    localparam logic signed [11:0] REST_OFFSET_Y_RST = -12'sd16;
    localparam logic [11:0]        START_THRESH_RST  = 12'd20;
    localparam logic [24:0]        STOP_ACCEL_RST    = 25'd20;
    localparam logic [15:0]        STOP_VEL_RST      = 16'd90;
    localparam logic [7:0]         MAX_FRAMES_RST    = 8'd12;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_START   = 2'd1,
        EV_SETTLED = 2'd2,
        EV_TIMEOUT = 2'd3
    } event_t;

endpackage

[src/motion_burst_integrator.sv]
// A sample transfer passes through the input register, then the result register, before its
// result shows. One sample per cycle, back to back, while result_ready stays high.
// The result holds while result_ready is low; the input register can still take one sample.
// Reset (rst_n low, asynchronous) empties both registers, clears velocity, travel and
// frame count to zero and loads the configuration registers with their defaults.
// Depends on mbi_pkg.
module motion_burst_integrator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mbi_pkg::IDX_W-1:0]      cfg_index,
    input  logic [mbi_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  logic signed [11:0]             accel_x_mg,
    input  logic signed [11:0]             accel_y_mg,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic                           moving,
    output logic [1:0]                     event_code,
    output logic signed [21:0]             velocity_x,
    output logic signed [21:0]             velocity_y,
    output logic signed [31:0]             travel_x,
    output logic signed [31:0]             travel_y
);

    // Configuration registers.
    logic signed [11:0] rest_offset_x_reg;
    logic signed [11:0] rest_offset_y_reg;
    logic [11:0]        start_threshold_reg;
    logic [24:0]        stop_accel_sq_limit_reg;
    logic [15:0]        stop_velocity_threshold_reg;
    logic [7:0]         max_frames_reg;

    // Input and result registers.
    logic                                    s1_valid_reg;
    logic signed [11:0]                      ax_reg;
    logic signed [11:0]                      ay_reg;
    logic                                    result_valid_reg;
    mbi_pkg::event_t                         event_reg;

    // Burst state.
    logic [mbi_pkg::FC_W-1:0]                frame_count_reg;
    logic signed [mbi_pkg::VEL_W-1:0]        vel_x_reg;
    logic signed [mbi_pkg::VEL_W-1:0]        vel_y_reg;
    logic signed [mbi_pkg::TRV_W-1:0]        trv_x_reg;
    logic signed [mbi_pkg::TRV_W-1:0]        trv_y_reg;

    logic                                    s1_adv;

    logic signed [mbi_pkg::DEV_W-1:0]        dev_x;
    logic signed [mbi_pkg::DEV_W-1:0]        dev_y;
    logic signed [mbi_pkg::DSQ_W-1:0]        sq_x;
    logic signed [mbi_pkg::DSQ_W-1:0]        sq_y;
    logic [mbi_pkg::DSQ_W-1:0]               dev_sq;

    logic [23:0]                             start_sq;
    logic [31:0]                             vel_thresh_sq;
    logic signed [mbi_pkg::VEL_W:0]          vx_sum;
    logic signed [mbi_pkg::VEL_W:0]          vy_sum;
    logic signed [mbi_pkg::VEL_W-1:0]        vx_sat;
    logic signed [mbi_pkg::VEL_W-1:0]        vy_sat;
    logic signed [mbi_pkg::TRV_W:0]          tx_sum;
    logic signed [mbi_pkg::TRV_W:0]          ty_sum;
    logic signed [mbi_pkg::TRV_W-1:0]        tx_sat;
    logic signed [mbi_pkg::TRV_W-1:0]        ty_sat;
    logic signed [mbi_pkg::VSQ_W-1:0]        vsq_x;
    logic signed [mbi_pkg::VSQ_W-1:0]        vsq_y;
    logic [mbi_pkg::VSQ_W-1:0]               vsq;
    logic [mbi_pkg::FC_W-1:0]                fc_inc;
    logic                                    start_hit;
    logic                                    settle_hit;
    logic                                    timeout_hit;

    logic [mbi_pkg::FC_W-1:0]                frame_count_next;
    logic signed [mbi_pkg::VEL_W-1:0]        vel_x_next;
    logic signed [mbi_pkg::VEL_W-1:0]        vel_y_next;
    logic signed [mbi_pkg::TRV_W-1:0]        trv_x_next;
    logic signed [mbi_pkg::TRV_W-1:0]        trv_y_next;
    mbi_pkg::event_t                         event_next;

    // The input register hands its sample on when the result register is empty
    // or its result is being taken.
    assign s1_adv       = s1_valid_reg && (!result_valid_reg || result_ready);
    assign sample_ready = !s1_valid_reg || s1_adv;

    // Configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_offset_x_reg           <= mbi_pkg::REST_OFFSET_X_RST;
            rest_offset_y_reg           <= mbi_pkg::REST_OFFSET_Y_RST;
            start_threshold_reg         <= mbi_pkg::START_THRESH_RST;
            stop_accel_sq_limit_reg     <= mbi_pkg::STOP_ACCEL_RST;
            stop_velocity_threshold_reg <= mbi_pkg::STOP_VEL_RST;
            max_frames_reg              <= mbi_pkg::MAX_FRAMES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mbi_pkg::REG_REST_OFFSET_X:   rest_offset_x_reg           <= cfg_data[11:0];
                mbi_pkg::REG_REST_OFFSET_Y:   rest_offset_y_reg           <= cfg_data[11:0];
                mbi_pkg::REG_START_THRESHOLD: start_threshold_reg         <= cfg_data[11:0];
                mbi_pkg::REG_STOP_ACCEL_SQ:   stop_accel_sq_limit_reg     <= cfg_data[24:0];
                mbi_pkg::REG_STOP_VEL_THRESH: stop_velocity_threshold_reg <= cfg_data[15:0];
                mbi_pkg::REG_MAX_FRAMES:      max_frames_reg              <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            s1_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            ax_reg <= accel_x_mg;
            ay_reg <= accel_y_mg;
        end
    end

    // Deviation and its squared magnitude, independent of burst state.
    always_comb
    begin
        dev_x  = {ax_reg[11], ax_reg} - {rest_offset_x_reg[11], rest_offset_x_reg};
        dev_y  = {ay_reg[11], ay_reg} - {rest_offset_y_reg[11], rest_offset_y_reg};
        sq_x   = mbi_pkg::DSQ_W'(dev_x) * mbi_pkg::DSQ_W'(dev_x);
        sq_y   = mbi_pkg::DSQ_W'(dev_y) * mbi_pkg::DSQ_W'(dev_y);
        // Both squares stay below 2^24, so the sum cannot overflow.
        dev_sq = unsigned'(sq_x) + unsigned'(sq_y);
    end

    // Burst state update.
    always_comb
    begin
        start_sq      = 24'(start_threshold_reg) * 24'(start_threshold_reg);
        vel_thresh_sq = 32'(stop_velocity_threshold_reg) * 32'(stop_velocity_threshold_reg);

        vx_sum = {vel_x_reg[mbi_pkg::VEL_W-1], vel_x_reg}
               + {{(mbi_pkg::VEL_W + 1 - mbi_pkg::DEV_W){dev_x[mbi_pkg::DEV_W-1]}}, dev_x};
        vy_sum = {vel_y_reg[mbi_pkg::VEL_W-1], vel_y_reg}
               + {{(mbi_pkg::VEL_W + 1 - mbi_pkg::DEV_W){dev_y[mbi_pkg::DEV_W-1]}}, dev_y};

        // Overflow shows as a mismatch of the two top bits; the top bit gives the side.
        if (vx_sum[mbi_pkg::VEL_W] != vx_sum[mbi_pkg::VEL_W-1])
            vx_sat = {vx_sum[mbi_pkg::VEL_W], {(mbi_pkg::VEL_W-1){!vx_sum[mbi_pkg::VEL_W]}}};
        else
            vx_sat = vx_sum[mbi_pkg::VEL_W-1:0];
        if (vy_sum[mbi_pkg::VEL_W] != vy_sum[mbi_pkg::VEL_W-1])
            vy_sat = {vy_sum[mbi_pkg::VEL_W], {(mbi_pkg::VEL_W-1){!vy_sum[mbi_pkg::VEL_W]}}};
        else
            vy_sat = vy_sum[mbi_pkg::VEL_W-1:0];

        tx_sum = {trv_x_reg[mbi_pkg::TRV_W-1], trv_x_reg}
               + {{(mbi_pkg::TRV_W + 1 - mbi_pkg::VEL_W){vx_sat[mbi_pkg::VEL_W-1]}}, vx_sat};
        ty_sum = {trv_y_reg[mbi_pkg::TRV_W-1], trv_y_reg}
               + {{(mbi_pkg::TRV_W + 1 - mbi_pkg::VEL_W){vy_sat[mbi_pkg::VEL_W-1]}}, vy_sat};

        if (tx_sum[mbi_pkg::TRV_W] != tx_sum[mbi_pkg::TRV_W-1])
            tx_sat = {tx_sum[mbi_pkg::TRV_W], {(mbi_pkg::TRV_W-1){!tx_sum[mbi_pkg::TRV_W]}}};
        else
            tx_sat = tx_sum[mbi_pkg::TRV_W-1:0];
        if (ty_sum[mbi_pkg::TRV_W] != ty_sum[mbi_pkg::TRV_W-1])
            ty_sat = {ty_sum[mbi_pkg::TRV_W], {(mbi_pkg::TRV_W-1){!ty_sum[mbi_pkg::TRV_W]}}};
        else
            ty_sat = ty_sum[mbi_pkg::TRV_W-1:0];

        vsq_x = mbi_pkg::VSQ_W'(vx_sat) * mbi_pkg::VSQ_W'(vx_sat);
        vsq_y = mbi_pkg::VSQ_W'(vy_sat) * mbi_pkg::VSQ_W'(vy_sat);
        vsq   = unsigned'(vsq_x) + unsigned'(vsq_y);

        fc_inc      = frame_count_reg + 1'b1;
        start_hit   = dev_sq > {2'b00, start_sq};
        settle_hit  = (dev_sq < {1'b0, stop_accel_sq_limit_reg})
                   && (vsq < {{(mbi_pkg::VSQ_W - 32){1'b0}}, vel_thresh_sq});
        timeout_hit = fc_inc > {1'b0, max_frames_reg};

        frame_count_next = frame_count_reg;
        vel_x_next       = vel_x_reg;
        vel_y_next       = vel_y_reg;
        trv_x_next       = trv_x_reg;
        trv_y_next       = trv_y_reg;
        event_next       = mbi_pkg::EV_NONE;

        if (frame_count_reg == '0)
        begin
            // The sample that starts a burst is never checked for a stop.
            if (start_hit)
            begin
                vel_x_next       = {{(mbi_pkg::VEL_W - mbi_pkg::DEV_W){dev_x[mbi_pkg::DEV_W-1]}},
                                    dev_x};
                vel_y_next       = {{(mbi_pkg::VEL_W - mbi_pkg::DEV_W){dev_y[mbi_pkg::DEV_W-1]}},
                                    dev_y};
                trv_x_next       = '0;
                trv_y_next       = '0;
                frame_count_next = {{(mbi_pkg::FC_W-1){1'b0}}, 1'b1};
                event_next       = mbi_pkg::EV_START;
            end
        end
        else
        begin
            vel_x_next       = vx_sat;
            vel_y_next       = vy_sat;
            trv_x_next       = tx_sat;
            trv_y_next       = ty_sat;
            frame_count_next = fc_inc;
            // A settled stop wins over a timeout on the same sample.
            if (settle_hit)
            begin
                frame_count_next = '0;
                event_next       = mbi_pkg::EV_SETTLED;
            end
            else if (timeout_hit)
            begin
                frame_count_next = '0;
                event_next       = mbi_pkg::EV_TIMEOUT;
            end
        end
    end

    // The state only changes when a result is loaded, so it doubles as the
    // result payload and holds while the result waits for its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            event_reg        <= mbi_pkg::EV_NONE;
            frame_count_reg  <= '0;
            vel_x_reg        <= '0;
            vel_y_reg        <= '0;
            trv_x_reg        <= '0;
            trv_y_reg        <= '0;
        end
        else
        begin
            if (!result_valid_reg || result_ready)
            begin
                result_valid_reg <= s1_valid_reg;
            end
            if (s1_adv)
            begin
                event_reg       <= event_next;
                frame_count_reg <= frame_count_next;
                vel_x_reg       <= vel_x_next;
                vel_y_reg       <= vel_y_next;
                trv_x_reg       <= trv_x_next;
                trv_y_reg       <= trv_y_next;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign moving       = frame_count_reg != '0;
    assign event_code   = event_reg;
    assign velocity_x   = vel_x_reg;
    assign velocity_y   = vel_y_reg;
    assign travel_x     = trv_x_reg;
    assign travel_y     = trv_y_reg;

`ifndef SYNTHESIS
    // A start always leaves a burst running; a stop always ends it.
    a_start_moving: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && event_code == mbi_pkg::EV_START |-> moving)
        else $error("burst start reported without a running burst");

    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (event_code == mbi_pkg::EV_SETTLED || event_code == mbi_pkg::EV_TIMEOUT)
        |-> !moving)
        else $error("burst stop reported while still moving");

    // A waiting result must not see the burst state move underneath it.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(frame_count_reg) && $stable(trv_x_reg)
                                          && $stable(vel_y_reg))
        else $error("burst state changed while a result was stalled");

    // A running burst never counts past the largest timeout limit.
    a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_count_reg[mbi_pkg::FC_W-1] |-> frame_count_reg[mbi_pkg::FC_W-2:0] == '0)
        else $error("frame count ran past its limit");
`endif

endmodule
